// File: rtl/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg
// Request/response types and codes for the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  localparam logic [1:0] REQ_ALLOC    = 2'd0;
  localparam logic [1:0] REQ_FREE     = 2'd1;
  localparam logic [1:0] REQ_SET_SIZE = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [19:0] FREE_TOTAL_MAX = 20'hFFFFF;
  localparam logic [4:0]  FREE_CNT_MAX   = 5'd31;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  block_index;
    logic [15:0] request_size;
    logic [15:0] owner_id;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  chosen_index;
    logic [19:0] free_total_kb;
    logic [4:0]  free_count;
  } rsp_t;

endpackage

// File: rtl/fpfa_ram.sv
// ----------------------------------------------------------------------------
// fpfa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fpfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/fixed_partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed partition allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request walks
// all NUM_BLOCKS partitions, one read of the size and owner memories per
// cycle, then passes a drain state and commits in a single commit state; busy
// stays high through the scan, drain and commit states. The result comes on
// rsp_o with done_o high for a single cycle. The receiver cannot stall; rsp_o
// keeps a result until the next commit, and only the strobe marks it. The
// free total and free count are running registers, so no clearing pass is
// needed after reset. fit_strategy may only be written while busy is low.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  fpfa_pkg::req_t   req_i,
  output logic             done_o,
  output fpfa_pkg::rsp_t   rsp_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i
);

  localparam int IW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW0 = $clog2(NUM_BLOCKS + 1);
  localparam int CW  = (CW0 > 5) ? CW0 : 6;
  localparam int TW  = (16 + CW0 > 20) ? 16 + CW0 : 21;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_COMMIT} state_e;

  state_e          state_q, state_d;
  fpfa_pkg::req_t  req_q, req_d;
  logic [1:0]      strat_q, strat_d;
  logic [IW-1:0]   rd_idx_q, rd_idx_d;
  logic            pend_q, pend_d;
  logic [IW-1:0]   pend_idx_q, pend_idx_d;
  logic            found_q, found_d;
  logic [IW-1:0]   pick_idx_q, pick_idx_d;
  logic [15:0]     pick_size_q, pick_size_d;
  logic [15:0]     old_size_q, old_size_d;
  logic [NUM_BLOCKS-1:0] used_q, used_d;
  logic [NUM_BLOCKS-1:0] sv_q, sv_d;
  logic [TW-1:0]   total_q, total_d;
  logic [CW-1:0]   count_q, count_d;
  logic            done_q, done_d;
  fpfa_pkg::rsp_t  rsp_q, rsp_d;

  logic            size_we, own_we;
  logic [IW-1:0]   size_waddr;
  logic [15:0]     size_rdata, own_rdata, esize;
  logic            bidx_ok, last_rd, cand, take;
  logic [IW-1:0]   bidx;

  fpfa_ram #(.WIDTH(16), .DEPTH(NUM_BLOCKS)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (size_waddr),
    .wdata_i (req_q.request_size),
    .raddr_i (rd_idx_q),
    .rdata_o (size_rdata)
  );

  fpfa_ram #(.WIDTH(16), .DEPTH(NUM_BLOCKS)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (pick_idx_q),
    .wdata_i (req_q.owner_id),
    .raddr_i (rd_idx_q),
    .rdata_o (own_rdata)
  );

  assign busy    = (state_q != ST_IDLE);
  assign done_o  = done_q;
  assign rsp_o   = rsp_q;
  assign bidx    = IW'(req_q.block_index);
  assign bidx_ok = (32'(req_q.block_index) < NUM_BLOCKS);
  assign last_rd = (rd_idx_q == IW'(NUM_BLOCKS - 1));
  // never-written sizes read as zero
  assign esize   = sv_q[pend_idx_q] ? size_rdata : 16'd0;

  always_comb begin
    cand = 1'b0;
    take = 1'b0;
    case (req_q.req_type)
      fpfa_pkg::REQ_ALLOC: begin
        cand = !used_q[pend_idx_q] && (esize >= req_q.request_size);
        take = cand && (!found_q ||
               (strat_q == fpfa_pkg::FIT_BEST  && esize < pick_size_q) ||
               (strat_q == fpfa_pkg::FIT_WORST && esize > pick_size_q));
      end
      fpfa_pkg::REQ_FREE: begin
        take = used_q[pend_idx_q] && (own_rdata == req_q.owner_id) && !found_q;
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    strat_d     = strat_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    found_d     = found_q;
    pick_idx_d  = pick_idx_q;
    pick_size_d = pick_size_q;
    old_size_d  = old_size_q;
    used_d      = used_q;
    sv_d        = sv_q;
    total_d     = total_q;
    count_d     = count_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    size_we     = 1'b0;
    own_we      = 1'b0;
    size_waddr  = bidx;

    if (cfg_we_i) begin
      strat_d = cfg_wdata_i;
    end

    if (pend_q) begin
      if (take) begin
        found_d     = 1'b1;
        pick_idx_d  = pend_idx_q;
        pick_size_d = esize;
      end
      if (pend_idx_q == bidx) begin
        old_size_d = esize;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d    = req_i;
          rd_idx_d = '0;
          found_d  = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pend_d     = 1'b1;
        pend_idx_d = rd_idx_q;
        if (last_rd) begin
          state_d = ST_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        rsp_d.ok           = 1'b0;
        rsp_d.chosen_index = 4'd0;
        case (req_q.req_type)
          fpfa_pkg::REQ_ALLOC: begin
            if (found_q) begin
              used_d[pick_idx_q] = 1'b1;
              own_we             = 1'b1;
              total_d            = total_q - TW'(pick_size_q);
              count_d            = count_q - 1'b1;
              rsp_d.ok           = 1'b1;
              rsp_d.chosen_index = 4'(pick_idx_q);
            end
          end
          fpfa_pkg::REQ_FREE: begin
            if (found_q) begin
              used_d[pick_idx_q] = 1'b0;
              total_d            = total_q + TW'(pick_size_q);
              count_d            = count_q + 1'b1;
              rsp_d.ok           = 1'b1;
              rsp_d.chosen_index = 4'(pick_idx_q);
            end
          end
          fpfa_pkg::REQ_SET_SIZE: begin
            if (bidx_ok) begin
              size_we    = 1'b1;
              sv_d[bidx] = 1'b1;
              if (!used_q[bidx]) begin
                total_d = total_q - TW'(old_size_q) + TW'(req_q.request_size);
              end
              rsp_d.ok           = 1'b1;
              rsp_d.chosen_index = req_q.block_index;
            end
          end
          default: begin
          end
        endcase
        rsp_d.free_total_kb = (total_d > TW'(fpfa_pkg::FREE_TOTAL_MAX)) ?
                              fpfa_pkg::FREE_TOTAL_MAX : total_d[19:0];
        rsp_d.free_count    = (count_d > CW'(fpfa_pkg::FREE_CNT_MAX)) ?
                              fpfa_pkg::FREE_CNT_MAX : count_d[4:0];
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strat_q  <= fpfa_pkg::FIT_FIRST;
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      used_q   <= '0;
      sv_q     <= '0;
      total_q  <= '0;
      count_q  <= CW'(NUM_BLOCKS);
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      strat_q  <= strat_d;
      rd_idx_q <= rd_idx_d;
      pend_q   <= pend_d;
      found_q  <= found_d;
      used_q   <= used_d;
      sv_q     <= sv_d;
      total_q  <= total_d;
      count_q  <= count_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    pend_idx_q  <= pend_idx_d;
    pick_idx_q  <= pick_idx_d;
    pick_size_q <= pick_size_d;
    old_size_q  <= old_size_d;
    rsp_q       <= rsp_d;
  end

  a_count_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == NUM_BLOCKS - $countones(used_q))
    else $error("free count out of step with allocated flags");

  a_done_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_COMMIT))
    else $error("result strobe without a commit");

  a_accept_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_fail_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.ok) |-> (rsp_o.chosen_index == 4'd0))
    else $error("failed request reports nonzero index");

  a_no_ram_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_we || own_we) |-> (state_q == ST_COMMIT))
    else $error("memory write outside commit");

endmodule
